// File: rtl/mcds_pkg.sv
// Shared types and constants for the multi-character delimiter splitter.
// No dependencies; imported by every module of the block.
`default_nettype none
package mcds_pkg;

  localparam int MAX_SEP   = 8;
  localparam int MAX_LEN   = 65535;
  localparam int CNT_W     = 16;
  localparam int SYM_W     = 8;
  localparam int SEP_W     = 64;
  localparam int SLEN_W    = 4;
  localparam int CFG_AW    = 1;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;
  localparam int OUT_DW    = 32;

  localparam logic [CFG_AW-1:0] REG_SEP_CHARS = 1'd0;
  localparam logic [CFG_AW-1:0] REG_SEP_LEN   = 1'd1;

  // One accepted item's results: an optional separator hit, an optional end.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hit_start;
    logic [CNT_W-1:0] hit_end;
    logic             hit_ovf;
    logic             ends;
    logic [CNT_W-1:0] end_start;
    logic [CNT_W-1:0] end_end;
    logic             end_ovf;
  } seg_event_t;

endpackage
`default_nettype wire

// File: rtl/mcds_front.sv
// Front end: accepts characters, keeps the match window and offsets, and
// classifies each item into a segment event. Depends on mcds_pkg.
`default_nettype none
module mcds_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [mcds_pkg::SYM_W-1:0] symbol,
  input  wire logic                      carries_symbol,
  input  wire logic                      ends_string,
  input  wire logic [mcds_pkg::SEP_W-1:0] sep_chars,
  input  wire logic [mcds_pkg::SLEN_W-1:0] sep_len,
  output logic                           push,
  output mcds_pkg::seg_event_t           ev
);
  import mcds_pkg::*;

  logic [SYM_W-1:0] recent_r [MAX_SEP];
  logic [SYM_W-1:0] recent_nxt [MAX_SEP];
  logic [SYM_W-1:0] win [MAX_SEP];
  logic [CNT_W-1:0] count_r, count_nxt, seg_begin_r, seg_begin_nxt;
  logic             overflowed_r, overflowed_nxt;
  logic             sym_take, ovf_now, proc, match, hit, ovf_after;
  logic [CNT_W-1:0] cnt_new, seglen;
  logic [SLEN_W-1:0] eff_len;

  always_comb begin
    logic [SLEN_W-1:0] idx;
    sym_take  = acc && carries_symbol;
    ovf_now   = sym_take && (count_r == CNT_W'(MAX_LEN));
    proc      = sym_take && !ovf_now;
    ovf_after = overflowed_r | ovf_now;
    cnt_new   = count_r + CNT_W'(1);
    if (sep_len == '0) begin
      eff_len = SLEN_W'(1);
    end else if (sep_len > SLEN_W'(MAX_SEP)) begin
      eff_len = SLEN_W'(MAX_SEP);
    end else begin
      eff_len = sep_len;
    end
    win[0] = symbol;
    for (int j = 1; j < MAX_SEP; j++) begin
      win[j] = recent_r[j-1];
    end
    match = 1'b1;
    for (int i = 0; i < MAX_SEP; i++) begin
      idx = eff_len - SLEN_W'(1) - SLEN_W'(i);
      if ((SLEN_W'(i) < eff_len) && (win[idx[2:0]] != sep_chars[8*i +: 8])) begin
        match = 1'b0;
      end
    end
    seglen = cnt_new - seg_begin_r;
    hit    = proc && (seglen >= CNT_W'(eff_len)) && match;

    recent_nxt     = recent_r;
    count_nxt      = count_r;
    seg_begin_nxt  = seg_begin_r;
    overflowed_nxt = overflowed_r;
    if (acc) begin
      if (proc) begin
        recent_nxt = win;
        count_nxt  = cnt_new;
        if (hit) begin
          seg_begin_nxt = cnt_new;
        end
      end
      overflowed_nxt = ovf_after;
      if (ends_string) begin
        for (int j = 0; j < MAX_SEP; j++) begin
          recent_nxt[j] = '0;
        end
        count_nxt      = '0;
        seg_begin_nxt  = '0;
        overflowed_nxt = 1'b0;
      end
    end

    push         = acc && (hit || ends_string);
    ev.hit       = hit;
    ev.hit_start = seg_begin_r;
    ev.hit_end   = cnt_new - CNT_W'(eff_len);
    ev.hit_ovf   = overflowed_r;
    ev.ends      = ends_string;
    ev.end_start = hit ? cnt_new : seg_begin_r;
    ev.end_end   = proc ? cnt_new : count_r;
    ev.end_ovf   = ovf_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_SEP; j++) begin
        recent_r[j] <= '0;
      end
      count_r      <= '0;
      seg_begin_r  <= '0;
      overflowed_r <= 1'b0;
    end else begin
      recent_r     <= recent_nxt;
      count_r      <= count_nxt;
      seg_begin_r  <= seg_begin_nxt;
      overflowed_r <= overflowed_nxt;
    end
  end

  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    seg_begin_r <= count_r) else $error("segment begins past count");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ends_string |=> count_r == '0 && !overflowed_r)
    else $error("end of string did not clear state");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflowed_r |-> count_r == CNT_W'(MAX_LEN)) else $error("overflow below limit");
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    push && ev.hit |-> ev.hit_start <= ev.hit_end) else $error("hit segment reversed");

endmodule
`default_nettype wire

// File: rtl/mcds_fifo.sv
// Short event queue between front and back end.
// Depends on mcds_pkg for the event type and depth.
`default_nettype none
module mcds_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mcds_pkg::seg_event_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output mcds_pkg::seg_event_t      head
);
  import mcds_pkg::*;

  seg_event_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     wptr_r, rptr_r;
  logic [Q_AW:0]       count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (Q_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    Q_AW'(wptr_r - rptr_r) == count_r[Q_AW-1:0]) else $error("queue pointers disagree");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("request pushed into full queue");

endmodule
`default_nettype wire

// File: rtl/mcds_back.sv
// Back end: splits queued events into one or two segment results and
// holds them in the output register. Depends on mcds_pkg.
`default_nettype none
module mcds_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       head_valid,
  input  wire mcds_pkg::seg_event_t       head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mcds_pkg::OUT_DW-1:0]     out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);
  import mcds_pkg::*;

  logic              valid_r, valid_nxt;
  logic              hit_sent_r, hit_sent_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt, end_r, end_nxt;
  logic              last_r, last_nxt, ovf_r, ovf_nxt;
  logic              load;

  always_comb begin
    load         = head_valid && (!valid_r || out_tready);
    pop          = 1'b0;
    valid_nxt    = valid_r && !out_tready;
    hit_sent_nxt = hit_sent_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    last_nxt     = last_r;
    ovf_nxt      = ovf_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (head.hit && !hit_sent_r) begin
        start_nxt = head.hit_start;
        end_nxt   = head.hit_end;
        last_nxt  = 1'b0;
        ovf_nxt   = head.hit_ovf;
        if (head.ends) begin
          hit_sent_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        start_nxt    = head.end_start;
        end_nxt      = head.end_end;
        last_nxt     = 1'b1;
        ovf_nxt      = head.end_ovf;
        hit_sent_nxt = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      hit_sent_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      hit_sent_r <= hit_sent_nxt;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
    last_r  <= last_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {end_r, start_r};
  assign out_tlast  = last_r;
  assign out_tuser  = ovf_r;

  a_head_kind: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> head.hit || head.ends) else $error("queued event with no result");
  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    hit_sent_r |-> head_valid && head.hit && head.ends) else $error("split event lost");
  a_hit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    load && !pop |=> out_tvalid && !out_tlast) else $error("first of pair marked last");

endmodule
`default_nettype wire

// File: rtl/multi_char_delimiter_splitter.sv
// Splits a character stream on a separator of 1 to 8 characters.
// Each result passes through the event queue and then the output register before it is valid.
// The input takes one character per cycle while the queue is not full; an item with two results gives two outputs.
// A four-entry event queue decouples the input side from output stalls.
// Reset (rst_n low, synchronous) clears the window, offsets, queue and output valid;
// sep_chars resets to zero and sep_len to one. Depends on mcds_pkg and submodules.
`default_nettype none
module multi_char_delimiter_splitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // symbol
  input  wire logic                          in_tuser,   // carries_symbol
  input  wire logic                          in_tlast,   // ends_string
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [mcds_pkg::OUT_DW-1:0]        out_tdata,  // segment_start, segment_end
  output logic                               out_tuser,  // overflow
  output logic                               out_tlast,  // last_segment
  input  wire logic                          cfg_we,
  input  wire logic [mcds_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [mcds_pkg::SEP_W-1:0]    cfg_wdata
);
  import mcds_pkg::*;

  logic [SEP_W-1:0]  sep_chars_r;
  logic [SLEN_W-1:0] sep_len_r;
  logic              acc, push, full, pop, head_valid;
  seg_event_t        ev, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_chars_r <= '0;
      sep_len_r   <= SLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SEP_CHARS: sep_chars_r <= cfg_wdata;
        REG_SEP_LEN:   sep_len_r   <= cfg_wdata[SLEN_W-1:0];
        default:       sep_len_r   <= sep_len_r;
      endcase
    end
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  mcds_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .symbol         (in_tdata),
    .carries_symbol (in_tuser),
    .ends_string    (in_tlast),
    .sep_chars      (sep_chars_r),
    .sep_len        (sep_len_r),
    .push           (push),
    .ev             (ev)
  );

  mcds_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (ev),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mcds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
